[sv/tca_pkg.sv]
package tca_pkg;

  // fixed field widths
  localparam int RawW  = 14;
  localparam int OffW  = 10;
  localparam int CoefW = 16;
  localparam int AngInW = 15;
  localparam int ThrW  = 10;
  localparam int OutW  = 15;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  // offset sample, angle state (rad * 2^24), multiplier operands, accumulator
  localparam int SampW = RawW + 1;
  localparam int AngW  = 28;
  localparam int MulW  = 34;
  localparam int AccW  = 2 * MulW;
  localparam int TrigW = 32;

  localparam logic signed [AngW-1:0] HalfPiQ24 = 28'sd26353589;
  localparam logic signed [AngW-1:0] PiQ24     = 28'sd52707179;
  localparam logic signed [TrigW-1:0] GainQ30  = 32'sd652032875;
  localparam logic signed [AccW-1:0] OutMin    = -68'sd16384;
  localparam logic signed [AccW-1:0] OutMax    = 68'sd16383;

  typedef enum logic [2:0] {
    REG_OFFSET_X     = 3'd0,
    REG_OFFSET_Y     = 3'd1,
    REG_OFFSET_Z     = 3'd2,
    REG_AXIS_COEF    = 3'd3,
    REG_ANGLE_COEF   = 3'd4,
    REG_INITIAL_ANG  = 3'd5,
    REG_LEVEL_THRESH = 3'd6
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PRIME, ST_LPX, ST_LPY, ST_LPZ, ST_CHK, ST_ATAN, ST_ALP0, ST_ALP1,
    ST_SCLD, ST_ROT, ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_OUT
  } state_t;

  // arctangent of 2^-i, radians * 2^24
  function automatic logic signed [AngW-1:0] atan_q24(input logic [4:0] i);
    logic signed [AngW-1:0] v;
    case (i)
      5'd0:  v = 28'sd13176795;
      5'd1:  v = 28'sd7778716;
      5'd2:  v = 28'sd4110060;
      5'd3:  v = 28'sd2086331;
      5'd4:  v = 28'sd1047214;
      5'd5:  v = 28'sd524117;
      5'd6:  v = 28'sd262123;
      5'd7:  v = 28'sd131069;
      5'd8:  v = 28'sd65536;
      5'd9:  v = 28'sd32768;
      5'd10: v = 28'sd16384;
      5'd11: v = 28'sd8192;
      5'd12: v = 28'sd4096;
      5'd13: v = 28'sd2048;
      5'd14: v = 28'sd1024;
      5'd15: v = 28'sd512;
      5'd16: v = 28'sd256;
      5'd17: v = 28'sd128;
      5'd18: v = 28'sd64;
      5'd19: v = 28'sd32;
      5'd20: v = 28'sd16;
      5'd21: v = 28'sd8;
      5'd22: v = 28'sd4;
      5'd23: v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [OutW-1:0] sat_out(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] r;
    r = (v < OutMin) ? OutMin : ((v > OutMax) ? OutMax : v);
    return r[OutW-1:0];
  endfunction

endpackage

[sv/tilt_compensated_accel_filter_core.sv]
// channel   | direction | handshake               | payload
// in        | input     | in_valid / in_ready     | in_raw_x, in_raw_y, in_raw_z
// out       | output    | out_valid / out_ready   | out_level_x/y/z, out_tilt_angle,
//           |           |                         | out_angle_updated
// cfg       | input     | cfg_we (no wait)        | cfg_index, cfg_wdata
//
// one request at a time through a small sequencer around one shared multiplier
// and one shared shift-add cordic stage
// the first request only seeds the filter angle and emits no result
// reset (synchronous, rst_n low) restores register defaults and clears filter state
// a finished result waits in the output register; the next request is taken
// meanwhile and only its final step stalls until the output register frees
module tilt_compensated_accel_filter_core #(
  parameter int EXTRA_FRACTION_BITS = 8,
  parameter int ANGLE_ITERATIONS    = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [tca_pkg::RawW-1:0] in_raw_x,
  input  logic signed [tca_pkg::RawW-1:0] in_raw_y,
  input  logic signed [tca_pkg::RawW-1:0] in_raw_z,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [tca_pkg::OutW-1:0] out_level_x,
  output logic signed [tca_pkg::OutW-1:0] out_level_y,
  output logic signed [tca_pkg::OutW-1:0] out_level_z,
  output logic signed [tca_pkg::OutW-1:0] out_tilt_angle,
  output logic out_angle_updated,
  input  logic cfg_we,
  input  logic [tca_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [tca_pkg::CfgDataW-1:0] cfg_wdata
);

  // axis state width: offset sample plus extra fraction bits, one guard bit
  localparam int AxW = tca_pkg::SampW + EXTRA_FRACTION_BITS + 1;
  // cordic datapath: axis value scaled by 2^16 plus growth
  localparam int CW  = AxW + 20;
  localparam int IW  = $clog2(ANGLE_ITERATIONS);
  localparam int RndSh = 30 + EXTRA_FRACTION_BITS;
  localparam logic signed [tca_pkg::AccW-1:0] AxRnd =
    tca_pkg::AccW'((64'sd1 <<< EXTRA_FRACTION_BITS) >>> 1);
  localparam logic signed [tca_pkg::AccW-1:0] RotRnd =
    tca_pkg::AccW'(64'sd1 <<< (RndSh - 1));

  // configuration registers
  logic signed [tca_pkg::OffW-1:0]   off_x_r, off_y_r, off_z_r;
  logic [tca_pkg::CoefW-1:0]         k_axis_r, k_ang_r;
  logic signed [tca_pkg::AngInW-1:0] init_ang_r;
  logic [tca_pkg::ThrW-1:0]          thr_r;

  // sequencer and datapath
  tca_pkg::state_t state_r, state_nxt;
  logic primed_r, primed_nxt;
  logic signed [tca_pkg::SampW-1:0] xo_r, yo_r, zo_r;
  logic signed [AxW-1:0] sx_r, sx_nxt, sy_r, sy_nxt, sz_r, sz_nxt;
  logic signed [tca_pkg::AngW-1:0] sang_r, sang_nxt;
  logic signed [CW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [tca_pkg::AngW-1:0] ct_r, ct_nxt;
  logic vec_r, vec_nxt, flip_r, flip_nxt, upd_r, upd_nxt;
  logic [IW-1:0] iter_r, iter_nxt;
  logic signed [tca_pkg::TrigW-1:0] cos_r, cos_nxt, sin_r, sin_nxt;
  logic signed [tca_pkg::MulW-1:0] mul_a, mul_b;
  logic signed [tca_pkg::AccW-1:0] prod_r, acc_r, acc_nxt, ly_r, ly_nxt;

  logic out_valid_r;
  logic signed [tca_pkg::OutW-1:0] lx_o_r, ly_o_r, lz_o_r, ang_o_r;
  logic upd_o_r;

  logic in_fire, iter_last, y_big_first, y_big_filt, out_free;
  logic signed [tca_pkg::SampW-1:0] yo_abs;
  logic signed [AxW-1:0] sy_abs, thr_ax;
  logic ccw;
  logic signed [CW-1:0] shx, shy;
  logic signed [tca_pkg::AngW-1:0] atan_i;

  assign in_ready  = (state_r == tca_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign iter_last = (iter_r == IW'(ANGLE_ITERATIONS - 1));

  assign yo_abs      = (yo_r < 0) ? -yo_r : yo_r;
  assign y_big_first = yo_abs > $signed({1'b0, thr_r});
  assign sy_abs      = (sy_r < 0) ? -sy_r : sy_r;
  assign thr_ax      = AxW'($signed({1'b0, thr_r})) <<< EXTRA_FRACTION_BITS;
  assign y_big_filt  = sy_abs > thr_ax;

  // shared cordic stage: vectoring drives y to zero, rotation drives angle to zero
  assign ccw    = vec_r ? (cy_r < 0) : (ct_r >= 0);
  assign shx    = cx_r >>> iter_r;
  assign shy    = cy_r >>> iter_r;
  assign atan_i = tca_pkg::atan_q24(5'(iter_r));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r    <= 10'sd45;
      off_y_r    <= 10'sd0;
      off_z_r    <= 10'sd180;
      k_axis_r   <= 16'd3277;
      k_ang_r    <= 16'd131;
      init_ang_r <= 15'sd2145;
      thr_r      <= 10'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        tca_pkg::REG_OFFSET_X:     off_x_r    <= cfg_wdata[tca_pkg::OffW-1:0];
        tca_pkg::REG_OFFSET_Y:     off_y_r    <= cfg_wdata[tca_pkg::OffW-1:0];
        tca_pkg::REG_OFFSET_Z:     off_z_r    <= cfg_wdata[tca_pkg::OffW-1:0];
        tca_pkg::REG_AXIS_COEF:    k_axis_r   <= cfg_wdata;
        tca_pkg::REG_ANGLE_COEF:   k_ang_r    <= cfg_wdata;
        tca_pkg::REG_INITIAL_ANG:  init_ang_r <= cfg_wdata[tca_pkg::AngInW-1:0];
        tca_pkg::REG_LEVEL_THRESH: thr_r      <= cfg_wdata[tca_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tca_pkg::ST_IDLE:  if (in_fire) state_nxt = primed_r ? tca_pkg::ST_LPX : tca_pkg::ST_PRIME;
      tca_pkg::ST_PRIME: state_nxt = y_big_first ? tca_pkg::ST_ATAN : tca_pkg::ST_IDLE;
      tca_pkg::ST_LPX:   state_nxt = tca_pkg::ST_LPY;
      tca_pkg::ST_LPY:   state_nxt = tca_pkg::ST_LPZ;
      tca_pkg::ST_LPZ:   state_nxt = tca_pkg::ST_CHK;
      tca_pkg::ST_CHK:   state_nxt = y_big_filt ? tca_pkg::ST_ATAN : tca_pkg::ST_SCLD;
      tca_pkg::ST_ATAN:  if (iter_last) state_nxt = primed_r ? tca_pkg::ST_ALP0 : tca_pkg::ST_IDLE;
      tca_pkg::ST_ALP0:  state_nxt = tca_pkg::ST_ALP1;
      tca_pkg::ST_ALP1:  state_nxt = tca_pkg::ST_SCLD;
      tca_pkg::ST_SCLD:  state_nxt = tca_pkg::ST_ROT;
      tca_pkg::ST_ROT:   if (iter_last) state_nxt = tca_pkg::ST_M0;
      tca_pkg::ST_M0:    state_nxt = tca_pkg::ST_M1;
      tca_pkg::ST_M1:    state_nxt = tca_pkg::ST_M2;
      tca_pkg::ST_M2:    state_nxt = tca_pkg::ST_M3;
      tca_pkg::ST_M3:    state_nxt = tca_pkg::ST_M4;
      tca_pkg::ST_M4:    state_nxt = tca_pkg::ST_OUT;
      tca_pkg::ST_OUT:   if (out_free) state_nxt = tca_pkg::ST_IDLE;
      default:           state_nxt = tca_pkg::ST_IDLE;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      tca_pkg::ST_LPX: begin
        mul_a = (tca_pkg::MulW'(xo_r) <<< EXTRA_FRACTION_BITS) - tca_pkg::MulW'(sx_r);
        mul_b = tca_pkg::MulW'($signed({1'b0, k_axis_r}));
      end
      tca_pkg::ST_LPY: begin
        mul_a = (tca_pkg::MulW'(yo_r) <<< EXTRA_FRACTION_BITS) - tca_pkg::MulW'(sy_r);
        mul_b = tca_pkg::MulW'($signed({1'b0, k_axis_r}));
      end
      tca_pkg::ST_LPZ: begin
        mul_a = (tca_pkg::MulW'(zo_r) <<< EXTRA_FRACTION_BITS) - tca_pkg::MulW'(sz_r);
        mul_b = tca_pkg::MulW'($signed({1'b0, k_axis_r}));
      end
      tca_pkg::ST_ALP0: begin
        mul_a = tca_pkg::MulW'(ct_r) - tca_pkg::MulW'(sang_r);
        mul_b = tca_pkg::MulW'($signed({1'b0, k_ang_r}));
      end
      tca_pkg::ST_M0: begin
        mul_a = tca_pkg::MulW'(sin_r);
        mul_b = tca_pkg::MulW'(sz_r);
      end
      tca_pkg::ST_M1: begin
        mul_a = tca_pkg::MulW'(cos_r);
        mul_b = tca_pkg::MulW'(sy_r);
      end
      tca_pkg::ST_M2: begin
        mul_a = tca_pkg::MulW'(cos_r);
        mul_b = tca_pkg::MulW'(sz_r);
      end
      tca_pkg::ST_M3: begin
        mul_a = tca_pkg::MulW'(sin_r);
        mul_b = tca_pkg::MulW'(sy_r);
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    sx_nxt = sx_r;  sy_nxt = sy_r;  sz_nxt = sz_r;
    sang_nxt = sang_r;  primed_nxt = primed_r;
    cx_nxt = cx_r;  cy_nxt = cy_r;  ct_nxt = ct_r;
    vec_nxt = vec_r;  flip_nxt = flip_r;  upd_nxt = upd_r;
    iter_nxt = iter_r;
    cos_nxt = cos_r;  sin_nxt = sin_r;
    acc_nxt = acc_r;  ly_nxt = ly_r;
    case (state_r)
      tca_pkg::ST_PRIME: begin
        iter_nxt = '0;
        vec_nxt  = 1'b1;
        ct_nxt   = '0;
        // negative y: both inputs negated so the angle stays within half pi
        cx_nxt   = CW'(yo_abs) <<< 16;
        cy_nxt   = CW'((yo_r < 0) ? -zo_r : zo_r) <<< 16;
        if (!y_big_first) begin
          sang_nxt   = tca_pkg::AngW'(init_ang_r) <<< 11;
          primed_nxt = 1'b1;
        end
      end
      tca_pkg::ST_LPY: sx_nxt = sx_r + AxW'(prod_r >>> 16);
      tca_pkg::ST_LPZ: sy_nxt = sy_r + AxW'(prod_r >>> 16);
      tca_pkg::ST_CHK: begin
        sz_nxt   = sz_r + AxW'(prod_r >>> 16);
        upd_nxt  = y_big_filt;
        iter_nxt = '0;
        vec_nxt  = 1'b1;
        ct_nxt   = '0;
        cx_nxt   = CW'(sy_abs) <<< 16;
        cy_nxt   = CW'((sy_r < 0) ? -(sz_r + AxW'(prod_r >>> 16))
                                  : (sz_r + AxW'(prod_r >>> 16))) <<< 16;
      end
      tca_pkg::ST_ATAN, tca_pkg::ST_ROT: begin
        cx_nxt   = ccw ? cx_r - shy : cx_r + shy;
        cy_nxt   = ccw ? cy_r + shx : cy_r - shx;
        ct_nxt   = ccw ? ct_r - atan_i : ct_r + atan_i;
        iter_nxt = iter_r + 1'b1;
        if (iter_last && state_r == tca_pkg::ST_ATAN && !primed_r) begin
          sang_nxt   = ccw ? ct_r - atan_i : ct_r + atan_i;
          primed_nxt = 1'b1;
        end
        if (iter_last && state_r == tca_pkg::ST_ROT) begin
          cos_nxt = tca_pkg::TrigW'(flip_r ? -(ccw ? cx_r - shy : cx_r + shy)
                                           :  (ccw ? cx_r - shy : cx_r + shy));
          sin_nxt = tca_pkg::TrigW'(flip_r ? -(ccw ? cy_r + shx : cy_r - shx)
                                           :  (ccw ? cy_r + shx : cy_r - shx));
        end
      end
      tca_pkg::ST_ALP1: sang_nxt = sang_r + tca_pkg::AngW'(prod_r >>> 16);
      tca_pkg::ST_SCLD: begin
        // angle beyond half pi: turn by pi and negate the results
        iter_nxt = '0;
        vec_nxt  = 1'b0;
        cx_nxt   = CW'(tca_pkg::GainQ30);
        cy_nxt   = '0;
        flip_nxt = (sang_r > tca_pkg::HalfPiQ24) || (sang_r < -tca_pkg::HalfPiQ24);
        if (sang_r > tca_pkg::HalfPiQ24)       ct_nxt = sang_r - tca_pkg::PiQ24;
        else if (sang_r < -tca_pkg::HalfPiQ24) ct_nxt = sang_r + tca_pkg::PiQ24;
        else                                    ct_nxt = sang_r;
      end
      tca_pkg::ST_M1: acc_nxt = prod_r;
      tca_pkg::ST_M2: acc_nxt = acc_r + prod_r;
      tca_pkg::ST_M3: begin
        ly_nxt  = acc_r;
        acc_nxt = prod_r;
      end
      tca_pkg::ST_M4: acc_nxt = acc_r - prod_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tca_pkg::ST_IDLE;
      primed_r <= 1'b0;
      sx_r     <= '0;
      sy_r     <= '0;
      sz_r     <= '0;
      sang_r   <= '0;
      iter_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      primed_r <= primed_nxt;
      sx_r     <= sx_nxt;
      sy_r     <= sy_nxt;
      sz_r     <= sz_nxt;
      sang_r   <= sang_nxt;
      iter_r   <= iter_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      xo_r <= tca_pkg::SampW'(in_raw_x) + tca_pkg::SampW'(off_x_r);
      yo_r <= tca_pkg::SampW'(in_raw_y) + tca_pkg::SampW'(off_y_r);
      zo_r <= tca_pkg::SampW'(in_raw_z) + tca_pkg::SampW'(off_z_r);
    end
    prod_r <= mul_a * mul_b;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    ct_r   <= ct_nxt;
    vec_r  <= vec_nxt;
    flip_r <= flip_nxt;
    upd_r  <= upd_nxt;
    cos_r  <= cos_nxt;
    sin_r  <= sin_nxt;
    acc_r  <= acc_nxt;
    ly_r   <= ly_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == tca_pkg::ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == tca_pkg::ST_OUT && out_free) begin
      lx_o_r  <= tca_pkg::sat_out((tca_pkg::AccW'(sx_r) + AxRnd) >>> EXTRA_FRACTION_BITS);
      ly_o_r  <= tca_pkg::sat_out((ly_r + RotRnd) >>> RndSh);
      lz_o_r  <= tca_pkg::sat_out((acc_r + RotRnd) >>> RndSh);
      ang_o_r <= tca_pkg::sat_out((tca_pkg::AccW'(sang_r) + 68'sd1024) >>> 11);
      upd_o_r <= upd_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_level_x       = lx_o_r;
  assign out_level_y       = ly_o_r;
  assign out_level_z       = lz_o_r;
  assign out_tilt_angle    = ang_o_r;
  assign out_angle_updated = upd_o_r;

endmodule

[sv/tca_checker.sv]
module tca_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [tca_pkg::OutW-1:0] out_level_x,
  input logic signed [tca_pkg::OutW-1:0] out_tilt_angle
);

  // a request keeps the sequencer busy, so in_ready is low after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after a request was taken");

  // reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_level_x) && $stable(out_tilt_angle)))
    else $error("stalled result changed");

endmodule

bind tilt_compensated_accel_filter_core tca_checker u_tca_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_level_x    (out_level_x),
  .out_tilt_angle (out_tilt_angle)
);

[verif/tb_tilt_compensated_accel_filter_core.sv]
module tb_tilt_compensated_accel_filter_core;

  localparam int ExtraBits = 8;
  localparam int AngIters  = 16;
  localparam int IdleLimit = 20000;
  localparam int RandItems = 600;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [tca_pkg::RawW-1:0] in_raw_x, in_raw_y, in_raw_z;
  logic out_valid;
  logic out_ready;
  logic signed [tca_pkg::OutW-1:0] out_level_x, out_level_y, out_level_z, out_tilt_angle;
  logic out_angle_updated;
  logic cfg_we;
  logic [tca_pkg::CfgIdxW-1:0] cfg_index;
  logic [tca_pkg::CfgDataW-1:0] cfg_wdata;

  tilt_compensated_accel_filter_core #(
    .EXTRA_FRACTION_BITS(ExtraBits),
    .ANGLE_ITERATIONS(AngIters)
  ) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_raw_x(in_raw_x), .in_raw_y(in_raw_y), .in_raw_z(in_raw_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_level_x(out_level_x), .out_level_y(out_level_y), .out_level_z(out_level_z),
    .out_tilt_angle(out_tilt_angle), .out_angle_updated(out_angle_updated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // one expected level result
  typedef struct packed {
    logic signed [tca_pkg::OutW-1:0] lx;
    logic signed [tca_pkg::OutW-1:0] ly;
    logic signed [tca_pkg::OutW-1:0] lz;
    logic signed [tca_pkg::OutW-1:0] ang;
    logic                            upd;
  } level_t;

  // directed stimulus row; chk set where the result is typed in
  typedef struct {
    logic signed [tca_pkg::RawW-1:0] x, y, z;
    bit     chk;
    level_t res;
  } row_t;

  level_t level_q[$];
  int     fails;
  int     accepted_in, accepted_out, updates_seen;
  int     idle_cycles;

  // shadow registers and filter state of the predictor
  logic [tca_pkg::CfgDataW-1:0] shadow_reg[7];
  longint sm_x, sm_y, sm_z, sm_ang;
  bit     seeded;

  // ---------------------------------------------------------------- predictor
  function automatic longint sx(longint v, int w);
    longint m;
    m = (64'sd1 <<< w) - 1;
    v = v & m;
    if (v[w-1]) v = v - (64'sd1 <<< w);
    return v;
  endfunction

  // arithmetic shift rounds toward minus infinity for signed longint
  function automatic longint rnd_shr(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip_out(longint v);
    return v < -16384 ? -16384 : (v > 16383 ? 16383 : v);
  endfunction

  function automatic longint smooth_step(longint s, longint tgt, longint k);
    return s + ((k * (tgt - s)) >>> 16);
  endfunction

  function automatic longint atan_tab(int i);
    return longint'(tca_pkg::atan_q24(5'(i)));
  endfunction

  // vectoring cordic, atan(z/y) in rad * 2^24
  function automatic longint slope_angle(longint y, longint z);
    longint a, b, na, nb, acc;
    a = y; b = z; acc = 0;
    if (a < 0) begin
      a = -a;
      b = -b;
    end
    a = a * 65536;
    b = b * 65536;
    for (int i = 0; i < AngIters; i++) begin
      if (b >= 0) begin
        na = a + (b >>> i);
        nb = b - (a >>> i);
        acc += atan_tab(i);
      end else begin
        na = a - (b >>> i);
        nb = b + (a >>> i);
        acc -= atan_tab(i);
      end
      a = na;
      b = nb;
    end
    return acc;
  endfunction

  // rotation cordic, Q30 cos and sin
  task automatic sin_cos(input longint ang, output longint c, output longint s);
    longint x, y, t, nx, ny;
    bit flip;
    x = 652032875; y = 0; t = ang; flip = 0;
    if (t > 26353589) begin
      t -= 52707179;
      flip = 1;
    end else if (t < -26353589) begin
      t += 52707179;
      flip = 1;
    end
    for (int i = 0; i < AngIters; i++) begin
      if (t >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        t -= atan_tab(i);
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        t += atan_tab(i);
      end
      x = nx;
      y = ny;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic shadow_reset();
    shadow_reg[tca_pkg::REG_OFFSET_X]     = 45;
    shadow_reg[tca_pkg::REG_OFFSET_Y]     = 0;
    shadow_reg[tca_pkg::REG_OFFSET_Z]     = 180;
    shadow_reg[tca_pkg::REG_AXIS_COEF]    = 3277;
    shadow_reg[tca_pkg::REG_ANGLE_COEF]   = 131;
    shadow_reg[tca_pkg::REG_INITIAL_ANG]  = 2145;
    shadow_reg[tca_pkg::REG_LEVEL_THRESH] = 2;
    sm_x = 0; sm_y = 0; sm_z = 0; sm_ang = 0;
    seeded = 0;
  endtask

  // advance the predictor by one request; has_res = 0 for the seeding request
  task automatic predict_level(input logic signed [tca_pkg::RawW-1:0] rx, ry, rz,
                               output bit has_res, output level_t r);
    longint xo, yo, zo, thr, k, c, s, ly, lz;
    bit upd;
    xo = longint'(rx) + sx(shadow_reg[tca_pkg::REG_OFFSET_X], tca_pkg::OffW);
    yo = longint'(ry) + sx(shadow_reg[tca_pkg::REG_OFFSET_Y], tca_pkg::OffW);
    zo = longint'(rz) + sx(shadow_reg[tca_pkg::REG_OFFSET_Z], tca_pkg::OffW);
    thr = shadow_reg[tca_pkg::REG_LEVEL_THRESH][tca_pkg::ThrW-1:0];
    k = shadow_reg[tca_pkg::REG_AXIS_COEF];
    upd = 0;
    r = '0;
    has_res = 0;
    if (!seeded) begin
      // first request only seeds the angle
      seeded = 1;
      if ((yo < 0 ? -yo : yo) > thr) sm_ang = slope_angle(yo, zo);
      else sm_ang = sx(shadow_reg[tca_pkg::REG_INITIAL_ANG], tca_pkg::AngInW) * 2048;
      return;
    end
    sm_x = smooth_step(sm_x, xo <<< ExtraBits, k);
    sm_y = smooth_step(sm_y, yo <<< ExtraBits, k);
    sm_z = smooth_step(sm_z, zo <<< ExtraBits, k);
    if ((sm_y < 0 ? -sm_y : sm_y) > (thr <<< ExtraBits)) begin
      sm_ang = smooth_step(sm_ang, slope_angle(sm_y, sm_z),
                           longint'(shadow_reg[tca_pkg::REG_ANGLE_COEF]));
      upd = 1;
    end
    sin_cos(sm_ang, c, s);
    ly = rnd_shr(s * sm_z + c * sm_y, 30 + ExtraBits);
    lz = rnd_shr(c * sm_z - s * sm_y, 30 + ExtraBits);
    r.lx  = tca_pkg::OutW'(clip_out(rnd_shr(sm_x, ExtraBits)));
    r.ly  = tca_pkg::OutW'(clip_out(ly));
    r.lz  = tca_pkg::OutW'(clip_out(lz));
    r.ang = tca_pkg::OutW'(clip_out(rnd_shr(sm_ang, 11)));
    r.upd = upd;
    has_res = 1;
  endtask

  // ---------------------------------------------------------------- clock, reset
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
  end

  // ---------------------------------------------------------------- drivers
  function automatic int gap_len();
    // mostly short, a few long, many none
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // send one request; prediction happens at the accepting edge
  // in_valid stays high after acceptance until the next gap or drain lowers it
  task automatic send_request(input logic signed [tca_pkg::RawW-1:0] x, y, z,
                              input bit chk, input level_t typed);
    bit has_res;
    level_t r;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_raw_x <= x;
    in_raw_y <= y;
    in_raw_z <= z;
    do @(posedge clk); while (!in_ready);
    accepted_in++;
    predict_level(x, y, z, has_res, r);
    if (has_res) begin
      if (chk && typed != r) begin
        $display("%0t: typed row disagrees with predictor: exp %h act %h",
                 $time, typed, r);
        fails++;
      end
      level_q.push_back(r);
    end
  endtask

  // wait until the block is idle before a register write
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 0;
    while (level_q.size() != 0 && guard < IdleLimit) begin
      @(posedge clk);
      guard++;
    end
    // the seeding request leaves no result, so let its cycles pass
    repeat (2 * AngIters + 40) @(posedge clk);
  endtask

  function automatic int reg_width(tca_pkg::reg_idx_t idx);
    case (idx)
      tca_pkg::REG_AXIS_COEF, tca_pkg::REG_ANGLE_COEF: return tca_pkg::CoefW;
      tca_pkg::REG_INITIAL_ANG:                        return tca_pkg::AngInW;
      tca_pkg::REG_LEVEL_THRESH:                       return tca_pkg::ThrW;
      default:                                         return tca_pkg::OffW;
    endcase
  endfunction

  task automatic write_reg(input tca_pkg::reg_idx_t idx,
                           input logic [tca_pkg::CfgDataW-1:0] v);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    shadow_reg[idx] = v & tca_pkg::CfgDataW'((32'd1 << reg_width(idx)) - 1);
    @(posedge clk);
  endtask

  // random raw sample; mostly moderate values, sometimes full scale
  function automatic logic signed [tca_pkg::RawW-1:0] rand_raw();
    if ($urandom_range(0, 9) < 2) return tca_pkg::RawW'($urandom);
    return tca_pkg::RawW'($signed($urandom_range(0, 4095)) - 2048);
  endfunction

  // ---------------------------------------------------------------- result side
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (rst_n && $urandom_range(0, 99) < 70 && gap_len() == 0) out_ready <= 1;
      else if (rst_n && $urandom_range(0, 99) < 50) out_ready <= 1;
      else out_ready <= 0;
    end
  end

  // compare each accepted result against the oldest expectation
  always @(posedge clk) begin
    level_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      accepted_out++;
      if (level_q.size() == 0) begin
        $display("%0t: unexpected result lx %0d ly %0d lz %0d ang %0d upd %0b",
                 $time, out_level_x, out_level_y, out_level_z, out_tilt_angle,
                 out_angle_updated);
        fails++;
      end else begin
        exp_r = level_q.pop_front();
        if (out_angle_updated) updates_seen++;
        if (out_level_x !== exp_r.lx || out_level_y !== exp_r.ly ||
            out_level_z !== exp_r.lz || out_tilt_angle !== exp_r.ang ||
            out_angle_updated !== exp_r.upd) begin
          $display("%0t: mismatch exp lx %0d ly %0d lz %0d ang %0d upd %0b",
                   $time, exp_r.lx, exp_r.ly, exp_r.lz, exp_r.ang, exp_r.upd);
          $display("%0t:          act lx %0d ly %0d lz %0d ang %0d upd %0b",
                   $time, out_level_x, out_level_y, out_level_z, out_tilt_angle,
                   out_angle_updated);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: watchdog expired, %0d results pending", $time, level_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  row_t dir_rows[$];

  task automatic add_row(input int x, y, z, input bit chk = 0,
                         input level_t res = '0);
    row_t r;
    r.x = tca_pkg::RawW'(x); r.y = tca_pkg::RawW'(y); r.z = tca_pkg::RawW'(z);
    r.chk = chk; r.res = res;
    dir_rows.push_back(r);
  endtask

  initial begin
    level_t zero_res;
    int n;
    in_valid = 0;
    in_raw_x = '0; in_raw_y = '0; in_raw_z = '0;
    cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    fails = 0; accepted_in = 0; accepted_out = 0; updates_seen = 0;
    idle_cycles = 0;
    shadow_reset();
    @(posedge clk iff rst_n);
    @(posedge clk);

    // defaults after reset: small y seeds from initial angle, then zero input
    // with offsets cancelled gives zero axes and the seeded angle held
    add_row(-45, 0, -180);
    zero_res = '{lx: 0, ly: 0, lz: 0, ang: 2145, upd: 0};
    add_row(-45, 0, -180, 1, zero_res);
    // full-scale extremes, negative y, large tilt
    add_row(8191, 8191, 8191);
    add_row(-8192, -8192, -8192);
    add_row(8191, -8192, 8191);
    add_row(-8192, 8191, -8192);
    add_row(0, 2000, 0);
    add_row(0, -2000, 2000);
    add_row(0, 3, -3);
    add_row(100, 0, 2048);
    foreach (dir_rows[i])
      send_request(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                   dir_rows[i].chk, dir_rows[i].res);
    drain();

    // extreme settings: fastest filters, wrapped offsets, initial angle
    // beyond pi/2, top threshold, unknown index ignored
    write_reg(tca_pkg::REG_OFFSET_X, 16'h01FF);
    write_reg(tca_pkg::REG_OFFSET_Y, 16'h0200);
    write_reg(tca_pkg::REG_OFFSET_Z, 16'h03FF);
    write_reg(tca_pkg::REG_AXIS_COEF, 16'hFFFF);
    write_reg(tca_pkg::REG_ANGLE_COEF, 16'hFFFF);
    write_reg(tca_pkg::REG_INITIAL_ANG, 16'(-12868));
    write_reg(tca_pkg::REG_LEVEL_THRESH, 16'd1023);
    cfg_we <= 1; cfg_index <= 3'd7; cfg_wdata <= 16'hFFFF;
    @(posedge clk);
    cfg_we <= 0;
    for (int i = 0; i < 12; i++)
      send_request(rand_raw(), rand_raw(), rand_raw(), 0, '0);
    drain();

    // random phases, each with a fresh setting
    n = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(tca_pkg::REG_OFFSET_X, 16'($urandom));
      write_reg(tca_pkg::REG_OFFSET_Y, 16'($urandom));
      write_reg(tca_pkg::REG_OFFSET_Z, 16'($urandom));
      write_reg(tca_pkg::REG_AXIS_COEF,
                ph == 0 ? 16'd0 : 16'($urandom_range(500, 65535)));
      write_reg(tca_pkg::REG_ANGLE_COEF, ph == 1 ? 16'd0 : 16'($urandom));
      write_reg(tca_pkg::REG_INITIAL_ANG, ph == 2 ? 16'd12868 :
                16'($signed($urandom_range(0, 25736)) - 12868));
      write_reg(tca_pkg::REG_LEVEL_THRESH,
                ph == 3 ? 16'd0 : 16'($urandom_range(0, 1023)));
      for (int i = 0; i < RandItems / 6; i++) begin
        send_request(rand_raw(), rand_raw(), rand_raw(), 0, '0);
        n++;
      end
      drain();
    end

    // final wait, bounded
    begin
      int guard;
      guard = 0;
      while (level_q.size() != 0 && guard < IdleLimit) begin
        @(posedge clk);
        guard++;
      end
    end
    repeat (100) @(posedge clk);
    $display("requests sent %0d, results checked %0d (%0d with angle update)",
             accepted_in, accepted_out, updates_seen);
    $display("covered reset defaults, field extremes and %0d random settings phases", 6);
    if (fails == 0 && level_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
